// ----- rtl/core/itfr_pkg.sv -----
// itfr_pkg: shared types and constants of the idle timeout frame receiver
// no dependencies; used by the interfaces, all core modules and the checker

package itfr_pkg;

    // field widths
    localparam int OpW    = 2;
    localparam int DataW  = 8;
    localparam int CountW = 7;
    localparam int TimerW = 16;

    // defaults
    localparam int              BufferDepthDef = 64;
    localparam logic [TimerW-1:0] TimeoutRst   = 16'd10;

    // input opcodes
    typedef enum logic [OpW-1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    // sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // write request to the frame store (address travels separately)
    typedef struct packed {
        logic             en;
        logic [DataW-1:0] data;
    } t_wr_req;

endpackage

// ----- rtl/core/itfr_if.sv -----
// itfr_if: valid/ready channel interfaces for input words, result words and config
// depends on itfr_pkg

interface itfr_in_if;
    logic                         valid;
    logic                         ready;
    logic [itfr_pkg::OpW-1:0]     opcode;
    logic [itfr_pkg::DataW-1:0]   rx_byte;
    logic [itfr_pkg::CountW-1:0]  read_limit;

    modport source (output valid, output opcode, output rx_byte, output read_limit,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input read_limit,
                    output ready);
endinterface

interface itfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [itfr_pkg::DataW-1:0]   data_byte;
    logic [itfr_pkg::CountW-1:0]  delivered_count;
    logic                         is_last;
    logic                         empty_read;

    modport source (output valid, output data_byte, output delivered_count,
                    output is_last, output empty_read, input ready);
    modport sink   (input valid, input data_byte, input delivered_count,
                    input is_last, input empty_read, output ready);
endinterface

interface itfr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [itfr_pkg::TimerW-1:0]  idle_timeout_ticks;

    modport source (output valid, output idle_timeout_ticks, input ready);
    modport sink   (input valid, input idle_timeout_ticks, output ready);
endinterface

// ----- rtl/core/idle_timeout_frame_receiver.sv -----
// idle_timeout_frame_receiver: top level, frame store plus control
// depends on itfr_pkg, the channel interfaces, itfr_store and itfr_ctrl

// Collects received bytes into a frame store of BUFFER_DEPTH bytes held in a
// single-port-write, registered-read memory. After a byte word, a tick word or
// a config write the next word can be taken at once. A read word holds off
// further words until its last store read or its empty result is issued:
// the store is walked one address per cycle through its read port, so
// results stream at one per cycle while the output is not stalled. A waiting
// result word does not hold off byte and tick words. The store needs no
// clearing after reset; only bytes written since the last read with a
// nonzero limit are ever read back.

module idle_timeout_frame_receiver #(
    parameter int BUFFER_DEPTH = itfr_pkg::BufferDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itfr_in_if.sink     i_in,
    itfr_out_if.source  o_res,
    itfr_cfg_if.sink    i_cfg
);

    localparam int AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    itfr_pkg::t_wr_req          wr;
    logic [AddrW-1:0]           waddr;
    logic                       rd_en;
    logic [AddrW-1:0]           raddr;
    logic [itfr_pkg::DataW-1:0] rdata;

    // control and result path
    itfr_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AddrW        (AddrW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .o_wr    (wr),
        .o_waddr (waddr),
        .o_rd_en (rd_en),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // frame byte memory
    itfr_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AddrW        (AddrW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_waddr (waddr),
        .i_rd_en (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ----- rtl/core/itfr_store.sv -----
// itfr_store: frame byte memory, one write and one registered read port
// depends on itfr_pkg

module itfr_store #(
    parameter int BUFFER_DEPTH = itfr_pkg::BufferDepthDef,
    parameter int AddrW        = 6
) (
    input  logic                       i_clk,
    input  itfr_pkg::t_wr_req          i_wr,
    input  logic [AddrW-1:0]           i_waddr,
    input  logic                       i_rd_en,
    input  logic [AddrW-1:0]           i_raddr,
    output logic [itfr_pkg::DataW-1:0] o_rdata
);

    logic [itfr_pkg::DataW-1:0] r_mem [BUFFER_DEPTH];
    logic [itfr_pkg::DataW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    // read port, registered, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/itfr_ctrl.sv -----
// itfr_ctrl: frame state, idle timer, read sequencer and result register
// depends on itfr_pkg and the channel interfaces; drives itfr_store

module itfr_ctrl #(
    parameter int BUFFER_DEPTH = itfr_pkg::BufferDepthDef,
    parameter int AddrW        = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    itfr_in_if.sink                    i_in,
    itfr_out_if.source                 o_res,
    itfr_cfg_if.sink                   i_cfg,
    output itfr_pkg::t_wr_req          o_wr,
    output logic [AddrW-1:0]           o_waddr,
    output logic                       o_rd_en,
    output logic [AddrW-1:0]           o_raddr,
    input  logic [itfr_pkg::DataW-1:0] i_rdata
);

    localparam int CW = itfr_pkg::CountW;
    localparam int TW = itfr_pkg::TimerW;
    localparam int DW = itfr_pkg::DataW;
    localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);

    // control state
    itfr_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_frame_ready, n_frame_ready;
    logic [TW-1:0]    r_idle_cnt, n_idle_cnt;
    logic             r_timer_on, n_timer_on;
    logic [TW-1:0]    r_timeout;
    logic [CW-1:0]    r_total, n_total;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;

    // payload registers
    logic             r_pend_last, n_pend_last;
    logic [CW-1:0]    r_pend_count, n_pend_count;
    logic [DW-1:0]    r_out_data, n_out_data;
    logic [CW-1:0]    r_out_count, n_out_count;
    logic             r_out_last, n_out_last;
    logic             r_out_empty, n_out_empty;

    logic             accept;
    logic             out_free;
    logic             pend_move;
    logic [CW-1:0]    fill_inc;
    logic [TW-1:0]    cnt_inc;
    logic [TW-1:0]    limit;
    logic [CW-1:0]    rd_inc;

    assign i_in.ready = (r_state == itfr_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign pend_move  = r_pend && out_free;
    assign fill_inc   = r_fill + 1'b1;
    assign cnt_inc    = r_idle_cnt + 1'b1;
    assign limit      = (r_timeout == '0) ? TW'(1) : r_timeout;
    assign rd_inc     = r_rd_idx + 1'b1;

    // next state and outputs
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_frame_ready = r_frame_ready;
        n_idle_cnt    = r_idle_cnt;
        n_timer_on    = r_timer_on;
        n_total       = r_total;
        n_rd_idx      = r_rd_idx;
        n_pend        = r_pend;
        n_pend_last   = r_pend_last;
        n_pend_count  = r_pend_count;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_data    = r_out_data;
        n_out_count   = r_out_count;
        n_out_last    = r_out_last;
        n_out_empty   = r_out_empty;
        o_wr.en       = 1'b0;
        o_wr.data     = i_in.rx_byte;
        o_waddr       = r_fill[AddrW-1:0];
        o_rd_en       = 1'b0;
        o_raddr       = r_rd_idx[AddrW-1:0];

        // memory read word moves into the result register
        if (pend_move) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
            n_out_data  = i_rdata;
            n_out_count = r_pend_count;
            n_out_last  = r_pend_last;
            n_out_empty = 1'b0;
        end

        case (r_state)
            itfr_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in.opcode)
                        itfr_pkg::OP_BYTE: begin
                            // store byte while collecting with room left
                            if (!r_frame_ready && (r_fill < DepthC)) begin
                                o_wr.en    = 1'b1;
                                n_fill     = fill_inc;
                                n_idle_cnt = '0;
                                if (fill_inc >= DepthC) begin
                                    n_frame_ready = 1'b1;
                                    n_timer_on    = 1'b0;
                                end else begin
                                    n_timer_on = 1'b1;
                                end
                            end
                        end
                        itfr_pkg::OP_TICK: begin
                            // one-shot idle timer
                            if (r_timer_on) begin
                                if (cnt_inc >= limit) begin
                                    n_frame_ready = 1'b1;
                                    n_timer_on    = 1'b0;
                                    n_idle_cnt    = '0;
                                end else begin
                                    n_idle_cnt = cnt_inc;
                                end
                            end
                        end
                        itfr_pkg::OP_READ: begin
                            n_state  = itfr_pkg::ST_READ;
                            n_rd_idx = '0;
                            if (i_in.read_limit == '0) begin
                                n_total = '0;
                            end else begin
                                if (!r_frame_ready || (r_fill == '0)) begin
                                    n_total = '0;
                                end else if (r_fill < i_in.read_limit) begin
                                    n_total = r_fill;
                                end else begin
                                    n_total = i_in.read_limit;
                                end
                                n_fill        = '0;
                                n_frame_ready = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            itfr_pkg::ST_READ: begin
                if (r_total == '0) begin
                    // single empty result once earlier words are out
                    if (!r_pend && out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_count = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                        n_state     = itfr_pkg::ST_IDLE;
                    end
                end else if (!r_pend || pend_move) begin
                    // issue next store read
                    o_rd_en      = 1'b1;
                    n_pend       = 1'b1;
                    n_pend_last  = (rd_inc == r_total);
                    n_pend_count = r_total;
                    n_rd_idx     = rd_inc;
                    if (rd_inc == r_total) begin
                        n_state = itfr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = itfr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= itfr_pkg::ST_IDLE;
            r_fill        <= '0;
            r_frame_ready <= 1'b0;
            r_idle_cnt    <= '0;
            r_timer_on    <= 1'b0;
            r_timeout     <= itfr_pkg::TimeoutRst;
            r_total       <= '0;
            r_rd_idx      <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill        <= n_fill;
            r_frame_ready <= n_frame_ready;
            r_idle_cnt    <= n_idle_cnt;
            r_timer_on    <= n_timer_on;
            r_total       <= n_total;
            r_rd_idx      <= n_rd_idx;
            r_pend        <= n_pend;
            r_out_valid   <= n_out_valid;
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.idle_timeout_ticks;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_last  <= n_pend_last;
        r_pend_count <= n_pend_count;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.data_byte       = r_out_data;
    assign o_res.delivered_count = r_out_count;
    assign o_res.is_last         = r_out_last;
    assign o_res.empty_read      = r_out_empty;

endmodule

// ----- rtl/core/itfr_checker.sv -----
// itfr_checker: port-level assertions on the frame receiver, bound to the top
// depends on itfr_pkg and idle_timeout_frame_receiver

module itfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [itfr_pkg::DataW-1:0]    i_data_byte,
    input logic [itfr_pkg::CountW-1:0]   i_delivered_count,
    input logic                          i_is_last,
    input logic                          i_empty_read
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_delivered_count) && $stable(i_is_last)
            && $stable(i_empty_read))
        else $error("result word changed while stalled");

    // an empty read is a single zero word marked last
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_read |-> i_is_last && (i_delivered_count == '0)
            && (i_data_byte == '0))
        else $error("malformed empty read result");

    // a data word always carries a nonzero count
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_empty_read |-> (i_delivered_count != '0))
        else $error("data word with zero count");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind idle_timeout_frame_receiver itfr_checker u_itfr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_data_byte       (o_res.data_byte),
    .i_delivered_count (o_res.delivered_count),
    .i_is_last         (o_res.is_last),
    .i_empty_read      (o_res.empty_read)
);
